/* design/vxm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vxm_pkg;

    localparam int CHUNK_SIZE_DEF = 16;
    localparam int CHUNKS_X_DEF   = 2;
    localparam int CHUNKS_Y_DEF   = 2;
    localparam int CHUNKS_Z_DEF   = 2;

    localparam int NUM_FACES   = 6;
    localparam int NUM_READS   = 13;  // neighbor + 4 corners x 3 samples
    localparam int VERTS_FACE  = 6;
    localparam logic [7:0] ID_GLASS = 8'd7;

    localparam int FACE_POS_Y = 0;
    localparam int FACE_NEG_Y = 1;

    // packed offset {dx, dy, dz}, each 2-bit two's complement
    function automatic logic [5:0] mk_ofs(input int dx, input int dy, input int dz);
        logic [5:0] r;
        r = {2'(dx), 2'(dy), 2'(dz)};
        return r;
    endfunction

    // per face: neighbor, then corner 0..3 as side, side, corner
    localparam logic [5:0] FACE_OFS [NUM_FACES][NUM_READS] = '{
        '{ mk_ofs(0,1,0),
           mk_ofs(0,1,-1),  mk_ofs(-1,1,0),  mk_ofs(-1,1,-1),
           mk_ofs(-1,1,0),  mk_ofs(0,1,1),   mk_ofs(-1,1,1),
           mk_ofs(0,1,1),   mk_ofs(1,1,0),   mk_ofs(1,1,1),
           mk_ofs(0,1,-1),  mk_ofs(1,1,0),   mk_ofs(1,1,-1) },
        '{ mk_ofs(0,-1,0),
           mk_ofs(0,-1,-1), mk_ofs(-1,-1,0), mk_ofs(-1,-1,-1),
           mk_ofs(-1,-1,0), mk_ofs(0,-1,1),  mk_ofs(-1,-1,1),
           mk_ofs(0,-1,1),  mk_ofs(1,-1,0),  mk_ofs(1,-1,1),
           mk_ofs(0,-1,-1), mk_ofs(1,-1,0),  mk_ofs(1,-1,-1) },
        '{ mk_ofs(1,0,0),
           mk_ofs(1,0,-1),  mk_ofs(1,-1,0),  mk_ofs(1,-1,-1),
           mk_ofs(1,0,-1),  mk_ofs(1,1,0),   mk_ofs(1,1,-1),
           mk_ofs(1,1,0),   mk_ofs(1,0,1),   mk_ofs(1,1,1),
           mk_ofs(1,0,1),   mk_ofs(1,-1,0),  mk_ofs(1,-1,1) },
        '{ mk_ofs(-1,0,0),
           mk_ofs(-1,0,-1), mk_ofs(-1,-1,0), mk_ofs(-1,-1,-1),
           mk_ofs(-1,0,-1), mk_ofs(-1,1,0),  mk_ofs(-1,1,-1),
           mk_ofs(-1,1,0),  mk_ofs(-1,0,1),  mk_ofs(-1,1,1),
           mk_ofs(-1,0,1),  mk_ofs(-1,-1,0), mk_ofs(-1,-1,1) },
        '{ mk_ofs(0,0,-1),
           mk_ofs(-1,0,-1), mk_ofs(0,-1,-1), mk_ofs(-1,-1,-1),
           mk_ofs(-1,0,-1), mk_ofs(0,1,-1),  mk_ofs(-1,1,-1),
           mk_ofs(0,1,-1),  mk_ofs(1,0,-1),  mk_ofs(1,1,-1),
           mk_ofs(0,-1,-1), mk_ofs(1,0,-1),  mk_ofs(1,-1,-1) },
        '{ mk_ofs(0,0,1),
           mk_ofs(-1,0,1),  mk_ofs(0,-1,1),  mk_ofs(-1,-1,1),
           mk_ofs(-1,0,1),  mk_ofs(0,1,1),   mk_ofs(-1,1,1),
           mk_ofs(0,1,1),   mk_ofs(1,0,1),   mk_ofs(1,1,1),
           mk_ofs(0,-1,1),  mk_ofs(1,0,1),   mk_ofs(1,-1,1) }
    };

    // vertex offset {x, y, z} per corner code
    localparam logic [2:0] FACE_POS [NUM_FACES][4] = '{
        '{3'b010, 3'b011, 3'b111, 3'b110},
        '{3'b000, 3'b001, 3'b101, 3'b100},
        '{3'b100, 3'b110, 3'b111, 3'b101},
        '{3'b000, 3'b010, 3'b011, 3'b001},
        '{3'b000, 3'b010, 3'b110, 3'b100},
        '{3'b001, 3'b011, 3'b111, 3'b101}
    };

    localparam logic [1:0] SEQ_NORM [NUM_FACES][VERTS_FACE] = '{
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}
    };

    localparam logic [1:0] SEQ_FLIP [NUM_FACES][VERTS_FACE] = '{
        '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2},
        '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0},
        '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2},
        '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}
    };

endpackage

`default_nettype wire

/* design/vxm_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface vxm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] pos_z;
    logic [7:0] block_id;
    logic [8:0] tex_top;
    logic [8:0] tex_bottom;
    logic [8:0] tex_side;

    modport source (output valid, req_type, pos_x, pos_y, pos_z, block_id,
                    tex_top, tex_bottom, tex_side, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, pos_z, block_id,
                    tex_top, tex_bottom, tex_side, output ready);
endinterface

interface vxm_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] vertex_word;
    logic        vertex_valid;
    logic        last_of_run;

    modport source (output valid, vertex_word, vertex_valid, last_of_run, input ready);
    modport sink   (input valid, vertex_word, vertex_valid, last_of_run, output ready);
endinterface

`default_nettype wire

/* design/voxel_mesher_with_ao.sv */
// Write item: after accept, S_FIN loads the acknowledge into the output register once
//   the output is free, and the block then returns to idle for the next item.
// Mesh item: a center read first; on air the item ends, else each face takes 13 reads
//   of the single voxel memory read port, one latency slot and AO, then 6 vertices if visible.
// One item at a time; results leave through an output register at one per cycle while res.ready holds.
// Reset (rst_n, async low) starts a clearing pass over the voxel memory, one cell
// per cycle (WX*WY*WZ cells, 32768 by default), during which no item is taken.
`timescale 1ns / 1ps
`default_nettype none

module voxel_mesher_with_ao #(
    parameter int CHUNK_SIZE = vxm_pkg::CHUNK_SIZE_DEF,
    parameter int CHUNKS_X   = vxm_pkg::CHUNKS_X_DEF,
    parameter int CHUNKS_Y   = vxm_pkg::CHUNKS_Y_DEF,
    parameter int CHUNKS_Z   = vxm_pkg::CHUNKS_Z_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vxm_req_if.sink    req,
    vxm_res_if.source  res
);

    localparam int WX    = CHUNK_SIZE * CHUNKS_X;
    localparam int WY    = CHUNK_SIZE * CHUNKS_Y;
    localparam int WZ    = CHUNK_SIZE * CHUNKS_Z;
    localparam int DEPTH = WX * WY * WZ;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CENTER, S_CWAIT, S_FRD, S_FAO, S_EMIT, S_FIN
    } state_t;

    state_t      state_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [4:0]  px_reg, py_reg, pz_reg;
    logic [5:0]  lx_reg, ly_reg, lz_reg;   // chunk-local block position
    logic [8:0]  tex_top_reg, tex_bot_reg, tex_side_reg;
    logic [2:0]  face_reg;
    logic [3:0]  k_reg;
    logic        rd_inw_reg;
    logic [7:0]  adj_reg;
    logic [11:0] samp_reg;
    logic [1:0]  ao_reg [4];
    logic        flip_reg;
    logic        pend_valid_reg;
    logic [31:0] pend_word_reg;
    logic        out_valid_reg, out_vv_reg, out_last_reg;
    logic [31:0] out_word_reg;

    // voxel memory
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] rd_addr;

    // chunk-local lookup, constant table
    logic [5:0] lmod_tab [32];
    for (genvar i = 0; i < 32; i++) begin : g_lmod
        assign lmod_tab[i] = 6'(i % CHUNK_SIZE);
    end

    logic accept, out_free, out_load;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;
    // output register is reloaded this cycle
    assign out_load  = ((state_reg == S_EMIT) && pend_valid_reg && out_free)
                    || ((state_reg == S_FIN) && out_free);

    // write path
    logic wr_inw;
    assign wr_inw = (32'(req.pos_x) < WX) && (32'(req.pos_y) < WY) && (32'(req.pos_z) < WZ);
    assign mem_we    = (state_reg == S_CLEAR) || (accept && !req.req_type && wr_inw);
    assign mem_wdata = (state_reg == S_CLEAR) ? 8'd0 : req.block_id;
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg :
        AW'((32'(req.pos_y) * WZ + 32'(req.pos_z)) * WX + 32'(req.pos_x));

    // read address: block position plus table offset (zero for the center read)
    logic [5:0] ofs;
    logic [6:0] qx, qy, qz;
    logic       rd_inw;
    logic [3:0] k_idx;
    assign k_idx = (k_reg > 4'(vxm_pkg::NUM_READS - 1)) ? 4'(vxm_pkg::NUM_READS - 1) : k_reg;
    assign ofs = (state_reg == S_FRD) ? vxm_pkg::FACE_OFS[face_reg][k_idx] : 6'd0;
    assign qx  = {2'b00, px_reg} + {{5{ofs[5]}}, ofs[5:4]};
    assign qy  = {2'b00, py_reg} + {{5{ofs[3]}}, ofs[3:2]};
    assign qz  = {2'b00, pz_reg} + {{5{ofs[1]}}, ofs[1:0]};
    assign rd_inw = !qx[6] && !qy[6] && !qz[6] && (32'(qx[5:0]) < WX)
                 && (32'(qy[5:0]) < WY) && (32'(qz[5:0]) < WZ);
    assign rd_addr = AW'((32'(qy[5:0]) * WZ + 32'(qz[5:0])) * WX + 32'(qx[5:0]));

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic [7:0] rd_val;
    assign rd_val = rd_inw_reg ? rd_data_reg : 8'd0;

    // corner occlusion from the gathered samples
    logic [1:0] ao_c [4];
    logic [2:0] diag_a, diag_b;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (adj_reg != 8'd0) begin
                ao_c[c] = 2'd2;
            end else if (samp_reg[c*3] && samp_reg[c*3+1]) begin
                ao_c[c] = 2'd0;
            end else begin
                ao_c[c] = 2'(2'd3 - 2'(samp_reg[c*3]) - 2'(samp_reg[c*3+1])
                               - 2'(samp_reg[c*3+2]));
            end
        end
        diag_a = 3'(ao_c[0]) + 3'(ao_c[2]);
        diag_b = 3'(ao_c[1]) + 3'(ao_c[3]);
    end

    // vertex assembly
    logic [1:0]  cc;
    logic [2:0]  vpos;
    logic [8:0]  layer;
    logic [31:0] vword;
    always_comb begin
        cc = flip_reg ? vxm_pkg::SEQ_FLIP[face_reg][k_reg[2:0]]
                      : vxm_pkg::SEQ_NORM[face_reg][k_reg[2:0]];
        vpos = vxm_pkg::FACE_POS[face_reg][cc];
        case (face_reg)
            3'(vxm_pkg::FACE_POS_Y): layer = tex_top_reg;
            3'(vxm_pkg::FACE_NEG_Y): layer = tex_bot_reg;
            default:                 layer = tex_side_reg;
        endcase
        vword = {layer, cc, 1'b0, ao_reg[cc], lz_reg + 6'(vpos[0]),
                 ly_reg + 6'(vpos[1]), lx_reg + 6'(vpos[2])};
    end

    logic transparent;
    assign transparent = (adj_reg == 8'd0) || (adj_reg == vxm_pkg::ID_GLASS);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            face_reg       <= '0;
            k_reg          <= '0;
            rd_inw_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            rd_inw_reg <= rd_inw;
            if (out_valid_reg && res.ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (32'(clr_cnt_reg) == DEPTH - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        px_reg         <= req.pos_x;
                        py_reg         <= req.pos_y;
                        pz_reg         <= req.pos_z;
                        lx_reg         <= lmod_tab[req.pos_x];
                        ly_reg         <= lmod_tab[req.pos_y];
                        lz_reg         <= lmod_tab[req.pos_z];
                        tex_top_reg    <= req.tex_top;
                        tex_bot_reg    <= req.tex_bottom;
                        tex_side_reg   <= req.tex_side;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= req.req_type ? S_CENTER : S_FIN;
                    end
                end
                S_CENTER: begin
                    state_reg <= S_CWAIT;
                end
                S_CWAIT: begin
                    face_reg  <= '0;
                    k_reg     <= '0;
                    state_reg <= (rd_val != 8'd0) ? S_FRD : S_FIN;
                end
                S_FRD: begin
                    // read k issued now, data of read k-1 arrives now
                    if (k_reg == 4'd1) begin
                        adj_reg <= rd_val;
                    end else if (k_reg != 4'd0) begin
                        samp_reg[k_reg - 4'd2] <= (rd_val != 8'd0);
                    end
                    if (k_reg == 4'(vxm_pkg::NUM_READS)) begin
                        state_reg <= S_FAO;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                S_FAO: begin
                    k_reg <= '0;
                    if (transparent) begin
                        for (int c = 0; c < 4; c++) begin
                            ao_reg[c] <= ao_c[c];
                        end
                        flip_reg  <= !(diag_a > diag_b);
                        state_reg <= S_EMIT;
                    end else if (face_reg == 3'(vxm_pkg::NUM_FACES - 1)) begin
                        state_reg <= S_FIN;
                    end else begin
                        face_reg  <= face_reg + 1'b1;
                        state_reg <= S_FRD;
                    end
                end
                S_EMIT: begin
                    // one vertex held back until we know whether it is the last
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            out_valid_reg <= 1'b1;
                            out_word_reg  <= pend_word_reg;
                            out_vv_reg    <= 1'b1;
                            out_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_word_reg  <= vword;
                        if (k_reg == 4'(vxm_pkg::VERTS_FACE - 1)) begin
                            k_reg <= '0;
                            if (face_reg == 3'(vxm_pkg::NUM_FACES - 1)) begin
                                state_reg <= S_FIN;
                            end else begin
                                face_reg  <= face_reg + 1'b1;
                                state_reg <= S_FRD;
                            end
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_word_reg   <= pend_valid_reg ? pend_word_reg : 32'd0;
                        out_vv_reg     <= pend_valid_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.vertex_word  = out_word_reg;
    assign res.vertex_valid = out_vv_reg;
    assign res.last_of_run  = out_last_reg;

    a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.vertex_valid) |-> res.last_of_run)
        else $error("empty result without last flag");

    a_pend_clear_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !pend_valid_reg)
        else $error("held vertex left over at new item");

    a_ao_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.vertex_valid) |-> !res.vertex_word[20])
        else $error("occlusion value out of range");

    a_write_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.req_type) |=> (state_reg == S_FIN))
        else $error("write item did not go to acknowledge");

endmodule

`default_nettype wire

/* bench/vxm_checker.sv */
`timescale 1ns / 1ps

module vxm_checker (
    input  logic clk,
    input  logic rst_n,
    vxm_req_if   req,
    vxm_res_if   res,
    output int   fails,
    output int   pending,
    output int   vertices
);

    localparam int SIDE = 32;
    localparam int CHUNK = 16;

    typedef struct packed {
        logic [31:0] word;
        logic        is_vertex;
        logic        last;
    } vertex_t;

    // neighbor offset per face: +y, -y, +x, -x, -z, +z
    localparam int NB [6][3] = '{
        '{0, 1, 0}, '{0, -1, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 0, -1}, '{0, 0, 1}
    };

    // per face, per corner: side, side, diagonal cell offsets
    localparam int SMP [6][12][3] = '{
        '{'{0,1,-1}, '{-1,1,0}, '{-1,1,-1}, '{-1,1,0}, '{0,1,1}, '{-1,1,1},
          '{0,1,1}, '{1,1,0}, '{1,1,1}, '{0,1,-1}, '{1,1,0}, '{1,1,-1}},
        '{'{0,-1,-1}, '{-1,-1,0}, '{-1,-1,-1}, '{-1,-1,0}, '{0,-1,1}, '{-1,-1,1},
          '{0,-1,1}, '{1,-1,0}, '{1,-1,1}, '{0,-1,-1}, '{1,-1,0}, '{1,-1,-1}},
        '{'{1,0,-1}, '{1,-1,0}, '{1,-1,-1}, '{1,0,-1}, '{1,1,0}, '{1,1,-1},
          '{1,1,0}, '{1,0,1}, '{1,1,1}, '{1,0,1}, '{1,-1,0}, '{1,-1,1}},
        '{'{-1,0,-1}, '{-1,-1,0}, '{-1,-1,-1}, '{-1,0,-1}, '{-1,1,0}, '{-1,1,-1},
          '{-1,1,0}, '{-1,0,1}, '{-1,1,1}, '{-1,0,1}, '{-1,-1,0}, '{-1,-1,1}},
        '{'{-1,0,-1}, '{0,-1,-1}, '{-1,-1,-1}, '{-1,0,-1}, '{0,1,-1}, '{-1,1,-1},
          '{0,1,-1}, '{1,0,-1}, '{1,1,-1}, '{0,-1,-1}, '{1,0,-1}, '{1,-1,-1}},
        '{'{-1,0,1}, '{0,-1,1}, '{-1,-1,1}, '{-1,0,1}, '{0,1,1}, '{-1,1,1},
          '{0,1,1}, '{1,0,1}, '{1,1,1}, '{0,-1,1}, '{1,0,1}, '{1,-1,1}}
    };

    // vertex offset per corner code
    localparam int CPOS [6][4][3] = '{
        '{'{0,1,0}, '{0,1,1}, '{1,1,1}, '{1,1,0}},
        '{'{0,0,0}, '{0,0,1}, '{1,0,1}, '{1,0,0}},
        '{'{1,0,0}, '{1,1,0}, '{1,1,1}, '{1,0,1}},
        '{'{0,0,0}, '{0,1,0}, '{0,1,1}, '{0,0,1}},
        '{'{0,0,0}, '{0,1,0}, '{1,1,0}, '{1,0,0}},
        '{'{0,0,1}, '{0,1,1}, '{1,1,1}, '{1,0,1}}
    };

    localparam int ORDER_A [6][6] = '{
        '{0,1,2,0,2,3}, '{0,2,1,0,3,2}, '{0,1,2,0,2,3},
        '{0,2,1,0,3,2}, '{0,1,2,0,2,3}, '{0,2,1,0,3,2}
    };
    localparam int ORDER_B [6][6] = '{
        '{3,0,1,3,1,2}, '{3,1,0,3,2,1}, '{1,2,3,1,3,0},
        '{3,1,0,3,2,1}, '{3,0,1,3,1,2}, '{3,1,0,3,2,1}
    };

    logic [7:0] world [SIDE*SIDE*SIDE];
    vertex_t    vertex_q [$];

    initial
    begin
        foreach (world[i]) world[i] = 8'd0;
        fails    = 0;
        vertices = 0;
    end

    assign pending = vertex_q.size();

    function automatic logic [7:0] cell_at(int x, int y, int z);
        if (x < 0 || x >= SIDE || y < 0 || y >= SIDE || z < 0 || z >= SIDE)
            return 8'd0;
        return world[(y * SIDE + z) * SIDE + x];
    endfunction

    task automatic push_done();
        vertex_t v;
        v = '{word: 32'd0, is_vertex: 1'b0, last: 1'b1};
        vertex_q.push_back(v);
    endtask

    // turns one accepted item into its expected results
    task automatic build_mesh(logic kind, int px, int py, int pz, logic [7:0] id,
                              logic [8:0] t_top, logic [8:0] t_bot, logic [8:0] t_side);
        logic [7:0] adj;
        int         ao [4];
        int         s [3];
        int         count;
        int         cc;
        logic [8:0] layer;
        logic [5:0] lx, ly, lz;
        vertex_t    v;
        count = 0;
        if (kind == 1'b0)
        begin
            world[(py * SIDE + pz) * SIDE + px] = id;
            push_done();
            return;
        end
        if (cell_at(px, py, pz) == 8'd0)
        begin
            push_done();
            return;
        end
        for (int f = 0; f < 6; f++)
        begin
            adj = cell_at(px + NB[f][0], py + NB[f][1], pz + NB[f][2]);
            if (adj != 8'd0 && adj != 8'd7)
                continue;
            layer = (f == 0) ? t_top : (f == 1) ? t_bot : t_side;
            for (int c = 0; c < 4; c++)
            begin
                for (int j = 0; j < 3; j++)
                    s[j] = (cell_at(px + SMP[f][c*3+j][0], py + SMP[f][c*3+j][1],
                                    pz + SMP[f][c*3+j][2]) != 8'd0) ? 1 : 0;
                if (adj != 8'd0)
                    ao[c] = 2;
                else if (s[0] == 1 && s[1] == 1)
                    ao[c] = 0;
                else
                    ao[c] = 3 - s[0] - s[1] - s[2];
            end
            for (int k = 0; k < 6; k++)
            begin
                cc = (ao[0] + ao[2] > ao[1] + ao[3]) ? ORDER_A[f][k] : ORDER_B[f][k];
                lx = 6'(px % CHUNK + CPOS[f][cc][0]);
                ly = 6'(py % CHUNK + CPOS[f][cc][1]);
                lz = 6'(pz % CHUNK + CPOS[f][cc][2]);
                v.word      = {layer, 2'(cc), 3'(ao[cc]), lz, ly, lx};
                v.is_vertex = 1'b1;
                v.last      = 1'b0;
                vertex_q.push_back(v);
                count++;
            end
        end
        if (count == 0)
            push_done();
        else
            vertex_q[vertex_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                build_mesh(req.req_type, req.pos_x, req.pos_y, req.pos_z, req.block_id,
                           req.tex_top, req.tex_bottom, req.tex_side);
            if (res.valid && res.ready)
            begin
                if (res.vertex_valid)
                    vertices++;
                if (vertex_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected item: word %h valid %b last %b",
                                 res.vertex_word, res.vertex_valid, res.last_of_run);
                end
                else
                begin
                    want = vertex_q.pop_front();
                    if (res.vertex_word !== want.word || res.vertex_valid !== want.is_vertex
                        || res.last_of_run !== want.last)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                     want.word, want.is_vertex, want.last,
                                     res.vertex_word, res.vertex_valid, res.last_of_run);
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_voxel_mesher_with_ao.sv */
`timescale 1ns / 1ps

module tb_voxel_mesher_with_ao;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_MESH  = 1'b1;
    localparam int   QUIET_LIMIT = 150000;  // several times the clearing pass after reset
    localparam int   HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    int   fails, pending, vertices;
    int   send_idle, recv_stall;
    int   hold_left;
    bit   hold_go;
    int   n_write, n_mesh;
    int   quiet;

    vxm_req_if req ();
    vxm_res_if res ();

    voxel_mesher_with_ao i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    vxm_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .res      (res),
        .fails    (fails),
        .pending  (pending),
        .vertices (vertices)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request so the block backs up
    initial
    begin
        res.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog: cycles without any accepted item on either side
    initial
    begin
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", quiet);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // one item on the request side; valid stays high across back-to-back items
    task automatic send_item(logic kind, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                             logic [7:0] id, logic [8:0] tt, logic [8:0] tb,
                             logic [8:0] ts);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= kind;
        req.pos_x      <= x;
        req.pos_y      <= y;
        req.pos_z      <= z;
        req.block_id   <= id;
        req.tex_top    <= tt;
        req.tex_bottom <= tb;
        req.tex_side   <= ts;
        do
            @(posedge clk);
        while (!req.ready);
        if (kind == KIND_WRITE)
            n_write++;
        else
            n_mesh++;
    endtask

    task automatic put_block(int x, int y, int z, int id);
        send_item(KIND_WRITE, 5'(x), 5'(y), 5'(z), 8'(id), 9'd0, 9'd0, 9'd0);
    endtask

    task automatic mesh_at(int x, int y, int z);
        send_item(KIND_MESH, 5'(x), 5'(y), 5'(z), 8'($urandom), 9'($urandom),
                  9'($urandom), 9'($urandom));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // random part: mostly clustered edits and meshes so neighbors matter
    task automatic random_items(int count);
        int cx, cy, cz, pick;
        int x, y, z;
        logic [7:0] id;
        cx = 2; cy = 2; cz = 2;
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
            begin
                cx = $urandom_range(29, 2);
                cy = $urandom_range(29, 2);
                cz = $urandom_range(29, 2);
            end
            if ($urandom_range(99) < 15)
            begin
                x = $urandom_range(31); y = $urandom_range(31); z = $urandom_range(31);
            end
            else
            begin
                x = cx - 2 + $urandom_range(4);
                y = cy - 2 + $urandom_range(4);
                z = cz - 2 + $urandom_range(4);
            end
            pick = $urandom_range(9);
            id = (pick < 3) ? 8'd0 : (pick < 5) ? 8'd7 : (pick < 7) ? 8'd1 : 8'($urandom);
            if ($urandom_range(99) < 60)
                send_item(KIND_WRITE, 5'(x), 5'(y), 5'(z), id, 9'($urandom),
                          9'($urandom), 9'($urandom));
            else
                mesh_at(x, y, z);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        hold_go        = 1'b0;
        n_write        = 0;
        n_mesh         = 0;
        send_idle      = 15;
        recv_stall     = 47;
        req.valid      = 1'b0;
        req.req_type   = KIND_WRITE;
        req.pos_x      = '0;
        req.pos_y      = '0;
        req.pos_z      = '0;
        req.block_id   = '0;
        req.tex_top    = '0;
        req.tex_bottom = '0;
        req.tex_side   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: air, lone blocks at both world corners (all faces, open AO)
        mesh_at(5, 5, 5);
        put_block(0, 0, 0, 255);
        send_item(KIND_MESH, 5'd0, 5'd0, 5'd0, 8'd0, 9'h1FF, 9'h000, 9'h155);
        put_block(31, 31, 31, 1);
        send_item(KIND_MESH, 5'd31, 5'd31, 5'd31, 8'hFF, 9'h000, 9'h1FF, 9'h0AA);
        // glass above forces occlusion 2 on the top face; solid below hides bottom
        put_block(10, 10, 10, 3);
        put_block(10, 11, 10, 7);
        put_block(10, 9, 10, 4);
        // side and corner cells near both blocks give further occlusion levels on their side faces
        put_block(9, 11, 10, 2);
        put_block(11, 10, 11, 5);
        put_block(11, 11, 11, 6);
        mesh_at(10, 10, 10);
        mesh_at(10, 11, 10);
        // fully enclosed block: every face hidden, empty mesh
        put_block(20, 20, 20, 9);
        put_block(20, 21, 20, 9);
        put_block(20, 19, 20, 9);
        put_block(21, 20, 20, 9);
        put_block(19, 20, 20, 9);
        put_block(20, 20, 19, 9);
        put_block(20, 20, 21, 9);
        mesh_at(20, 20, 20);
        // clearing a cell back to air
        put_block(31, 31, 31, 0);
        mesh_at(31, 31, 31);
        drain();

        // long receiver hold-off while items keep coming
        hold_go = 1'b1;
        random_items(40);
        drain();

        random_items(130);
        drain();
        send_idle = 47; recv_stall = 15;
        random_items(140);
        drain();
        send_idle = 0; recv_stall = 0;
        random_items(140);
        drain();

        repeat (200) @(posedge clk);
        $display("covered %0d writes and %0d mesh items, %0d vertices checked",
                 n_write, n_mesh, vertices);
        $display("idle mixes: 15/47, 47/15 and none, with one long output hold-off");
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
